>>> sv/fsmf_pkg.sv
// ---------------------------------------------------------------------------
// fsmf_pkg
// Shared widths, types and helpers for the five-sample mode filter.
// ---------------------------------------------------------------------------
package fsmf_pkg;

    localparam int NUM_SAMPLES = 5;
    localparam int SAMPLE_W    = 7;
    localparam int TAG_W       = 4;
    localparam int WIN_W       = 4;
    localparam int COUNT_W     = 3;

    localparam logic [WIN_W-1:0] WIN_RESET = 4'd1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [WIN_W-1:0]    win_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef sample_t [NUM_SAMPLES-1:0] sample_vec_t;
    typedef count_t  [NUM_SAMPLES-1:0] count_vec_t;

    // Tag and samples travelling together through the sorter
    typedef struct packed {
        tag_t        tag;
        sample_vec_t smp;
    } sort_word_t;

    function automatic sample_t smin(input sample_t a, input sample_t b);
        return (b < a) ? b : a;
    endfunction

    function automatic sample_t smax(input sample_t a, input sample_t b);
        return (b < a) ? a : b;
    endfunction

endpackage

>>> sv/fsmf_in_if.sv
// ---------------------------------------------------------------------------
// fsmf_in_if
// Input channel: group index and five samples with valid/ready.
// ---------------------------------------------------------------------------
interface fsmf_in_if
    import fsmf_pkg::*;
();
    logic    valid;
    logic    ready;
    tag_t    group_index;
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;

    modport source (
        output valid, group_index, sample_0, sample_1, sample_2, sample_3, sample_4,
        input  ready
    );
    modport sink (
        input  valid, group_index, sample_0, sample_1, sample_2, sample_3, sample_4,
        output ready
    );
endinterface

>>> sv/fsmf_out_if.sv
// ---------------------------------------------------------------------------
// fsmf_out_if
// Result channel: group tag, chosen value and its support count.
// ---------------------------------------------------------------------------
interface fsmf_out_if
    import fsmf_pkg::*;
();
    logic    valid;
    logic    ready;
    tag_t    group_tag;
    sample_t filtered_value;
    count_t  support_count;

    modport source (
        output valid, group_tag, filtered_value, support_count,
        input  ready
    );
    modport sink (
        input  valid, group_tag, filtered_value, support_count,
        output ready
    );
endinterface

>>> sv/fsmf_sorter.sv
// ---------------------------------------------------------------------------
// fsmf_sorter
// Two-stage nine-comparator sorting network for five samples, ascending.
// ---------------------------------------------------------------------------
module fsmf_sorter
    import fsmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sort_word_t in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output sort_word_t out_word
);

    logic       a_valid_reg;
    sort_word_t a_word_reg;
    sort_word_t a_word_next;
    logic       a_ready;

    logic       b_valid_reg;
    sort_word_t b_word_reg;
    sort_word_t b_word_next;
    logic       b_ready;

    sample_vec_t l1;
    sample_vec_t l2;
    sample_vec_t l3;
    sample_vec_t l4;
    sample_vec_t l5;
    sample_vec_t l6;

    // Stage A: first three comparator layers
    always_comb
    begin
        l1 = in_word.smp;
        l1[0] = smin(in_word.smp[0], in_word.smp[1]);
        l1[1] = smax(in_word.smp[0], in_word.smp[1]);
        l1[3] = smin(in_word.smp[3], in_word.smp[4]);
        l1[4] = smax(in_word.smp[3], in_word.smp[4]);

        l2 = l1;
        l2[2] = smin(l1[2], l1[4]);
        l2[4] = smax(l1[2], l1[4]);

        l3 = l2;
        l3[2] = smin(l2[2], l2[3]);
        l3[3] = smax(l2[2], l2[3]);
        l3[1] = smin(l2[1], l2[4]);
        l3[4] = smax(l2[1], l2[4]);

        a_word_next.tag = in_word.tag;
        a_word_next.smp = l3;
    end

    // Stage B: last three comparator layers
    always_comb
    begin
        l4 = a_word_reg.smp;
        l4[0] = smin(a_word_reg.smp[0], a_word_reg.smp[3]);
        l4[3] = smax(a_word_reg.smp[0], a_word_reg.smp[3]);

        l5 = l4;
        l5[0] = smin(l4[0], l4[2]);
        l5[2] = smax(l4[0], l4[2]);
        l5[1] = smin(l4[1], l4[3]);
        l5[3] = smax(l4[1], l4[3]);

        l6 = l5;
        l6[1] = smin(l5[1], l5[2]);
        l6[2] = smax(l5[1], l5[2]);

        b_word_next.tag = a_word_reg.tag;
        b_word_next.smp = l6;
    end

    // Each stage advances when empty or when its successor takes its word
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload: load only when a word moves in
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_word_reg <= a_word_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

>>> sv/five_sample_mode_filter.sv
// ---------------------------------------------------------------------------
// five_sample_mode_filter
// Cluster-mode filter: sorts five samples, counts neighbours within a
// programmable window and returns the first sample with the greatest count.
// ---------------------------------------------------------------------------
//
//   channel   | kind          | contents
//   ----------+---------------+----------------------------------------------
//   samples   | valid/ready   | group_index, sample_0 .. sample_4
//   result    | valid/ready   | group_tag, filtered_value, support_count
//   cfg       | write enable  | cfg_wr_data -> match_window
//
// Four register stages (two sorting, one window-count, one selection/output):
// an accepted word passes through them in that order, each stage registering its result.
// A new word is accepted every cycle unless the full pipeline is stalled by result.ready.
// Each stage has its own valid bit and holds its word while the stage after
// it is full and stalled, so bubbles close up behind a stalled result.
// Reset clears all valid bits and sets match_window to one.
// ---------------------------------------------------------------------------
module five_sample_mode_filter
    import fsmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fsmf_in_if.sink    samples,
    fsmf_out_if.source result,
    input  logic       cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data
);

    win_t       win_reg;

    sort_word_t in_word;
    sort_word_t srt_word;
    logic       srt_valid;

    logic        c_valid_reg;
    tag_t        c_tag_reg;
    sample_vec_t c_smp_reg;
    count_vec_t  c_cnt_reg;
    count_vec_t  c_cnt_next;
    logic        c_ready;

    logic    d_valid_reg;
    tag_t    d_tag_reg;
    sample_t d_value_reg;
    count_t  d_count_reg;
    sample_t d_value_next;
    count_t  d_count_next;
    logic    d_ready;

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            win_reg <= cfg_wr_data;
        end
    end

    // Pack the input word for the sorter
    always_comb
    begin
        in_word.tag    = samples.group_index;
        in_word.smp[0] = samples.sample_0;
        in_word.smp[1] = samples.sample_1;
        in_word.smp[2] = samples.sample_2;
        in_word.smp[3] = samples.sample_3;
        in_word.smp[4] = samples.sample_4;
    end

    fsmf_sorter u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_word   (in_word),
        .out_valid (srt_valid),
        .out_ready (c_ready),
        .out_word  (srt_word)
    );

    // Count neighbours of each sample; a zero sample never competes
    always_comb
    begin
        logic [SAMPLE_W:0] sk;
        logic [SAMPLE_W:0] sj;
        logic [SAMPLE_W:0] w;
        count_t            cnt;
        w = {{(SAMPLE_W + 1 - WIN_W){1'b0}}, win_reg};
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            sk  = {1'b0, srt_word.smp[k]};
            cnt = '0;
            for (int j = 0; j < NUM_SAMPLES; j++)
            begin
                sj = {1'b0, srt_word.smp[j]};
                if ((sj + w >= sk) && (sj <= sk + w))
                begin
                    cnt = cnt + count_t'(1);
                end
            end
            c_cnt_next[k] = (srt_word.smp[k] == '0) ? '0 : cnt;
        end
    end

    // Pick the first sorted sample with the strictly greatest count
    always_comb
    begin
        d_value_next = '0;
        d_count_next = '0;
        for (int k = 0; k < NUM_SAMPLES; k++)
        begin
            if (c_cnt_reg[k] > d_count_next)
            begin
                d_count_next = c_cnt_reg[k];
                d_value_next = c_smp_reg[k];
            end
        end
    end

    assign d_ready = !d_valid_reg || result.ready;
    assign c_ready = !c_valid_reg || d_ready;

    // Valid bits of the count and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= srt_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload: load only when a word moves in
    always_ff @(posedge clk)
    begin
        if (c_ready && srt_valid)
        begin
            c_tag_reg <= srt_word.tag;
            c_smp_reg <= srt_word.smp;
            c_cnt_reg <= c_cnt_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_tag_reg   <= c_tag_reg;
            d_value_reg <= d_value_next;
            d_count_reg <= d_count_next;
        end
    end

    assign result.valid          = d_valid_reg;
    assign result.group_tag      = d_tag_reg;
    assign result.filtered_value = d_value_reg;
    assign result.support_count  = d_count_reg;

`ifndef SYNTH
    // A chosen value is nonzero exactly when it has support
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.filtered_value == '0) == (result.support_count == '0)))
        else $error("filtered value and support count disagree");

    // Support never exceeds the number of samples
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.support_count <= count_t'(NUM_SAMPLES)))
        else $error("support count out of range");

    // A stalled count stage keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !d_ready) |=> (c_valid_reg && $stable(c_cnt_reg)
            && $stable(c_smp_reg) && $stable(c_tag_reg)))
        else $error("count stage lost its word under stall");

    // The sorter hands on ascending samples
    assert property (@(posedge clk) disable iff (!rst_n)
        srt_valid |-> (srt_word.smp[0] <= srt_word.smp[1]
            && srt_word.smp[1] <= srt_word.smp[2]
            && srt_word.smp[2] <= srt_word.smp[3]
            && srt_word.smp[3] <= srt_word.smp[4]))
        else $error("sorter output not ascending");
`endif

endmodule
